>>> design/line_window_mean_median_smoother_assert.svh
// ----------------------------------------------------------------------------
// Line window smoother assertion macros
// Short forms for the concurrent checks of the smoother.
// ----------------------------------------------------------------------------
`ifndef LINE_WINDOW_MEAN_MEDIAN_SMOOTHER_ASSERT_SVH
`define LINE_WINDOW_MEAN_MEDIAN_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define LWMS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lwms check failed");

// next-cycle implication
`define LWMS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lwms check failed");

`endif

>>> design/lwms_pkg.sv
// ----------------------------------------------------------------------------
// Line window smoother package
// Field widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package lwms_pkg;

   localparam int POS_W      = 16;
   localparam int RANK_W     = 8;
   localparam int OUT_W      = 12;
   localparam int HW_W       = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   localparam logic [OUT_W-1:0] OUT_LIMIT = 12'hFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WINDOW   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIAN_SELECT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAN,
      ST_EMIT,
      ST_GATHER,
      ST_INSERT,
      ST_MEDIAN,
      ST_MEDIAN_ADD,
      ST_ROUND,
      ST_DIV_START,
      ST_DIVIDE,
      ST_OUTPUT,
      ST_NEXT
   } lwms_state_type;

endpackage

>>> design/lwms_divider.sv
// ----------------------------------------------------------------------------
// Line window smoother divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lwms_divider #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/line_window_mean_median_smoother.sv
// ----------------------------------------------------------------------------
// Line window mean / median smoother
// Replaces each valid laser line sample by the mean or median of the valid
// positions around it, rounded to whole pixels; output lags by half_window.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req_     in         req_valid/req_ready    position, rank, end of line
//  rsp_     out        rsp_valid/rsp_ready    smoothed position, rank, done
//  csr_     in         csr_valid/csr_ready    index, data
//
// One item at a time; req_ready only in idle. An accepted item is planned, then
// each result has a setup step plus one gather step per window sample (W = up
// to 2*half_window+1). Median inserts each valid value into a sorted scratch
// list, then picks, adds and rounds the middle; mean runs the divider. Up to
// MAX_HALF_WINDOW+1 results per item, each held in the output register until
// taken. Reset is synchronous; no clearing pass.
module line_window_mean_median_smoother
   import lwms_pkg::*;
#(
   parameter int MAX_HALF_WINDOW        = 7,
   parameter int POSITION_FRACTION_BITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [POS_W-1:0]      req_line_position,
   input  logic [RANK_W-1:0]     req_sample_rank,
   input  logic                  req_end_of_line,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_W-1:0]      rsp_smoothed_position,
   output logic [RANK_W-1:0]     rsp_smoothed_rank,
   output logic                  rsp_line_done,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1;
   localparam int IDX_W     = $clog2(WIN_DEPTH);
   localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
   localparam int SUM_W     = POS_W + CNT_W;
   localparam int NUM_W     = SUM_W + POSITION_FRACTION_BITS + 2;
   localparam int DEN_W     = CNT_W + POSITION_FRACTION_BITS + 1;
   localparam int MED_W     = POS_W + 2;
   localparam logic [IDX_W-1:0] MAX_H    = IDX_W'(MAX_HALF_WINDOW);
   localparam logic [MED_W-1:0] MED_HALF = MED_W'(1) << POSITION_FRACTION_BITS;

   lwms_state_type state_ff, state_in;

   // configuration
   logic [HW_W-1:0]   half_window_ff;
   logic              median_ff;

   // window, newest at 0
   logic [POS_W-1:0]  pos_ff  [WIN_DEPTH];
   logic [RANK_W-1:0] rank_ff [WIN_DEPTH];
   logic [POS_W-1:0]  scratch_ff [WIN_DEPTH];
   logic              shift_en;
   logic              scr_we;
   logic [IDX_W-1:0]  scr_waddr;
   logic [POS_W-1:0]  scr_wdata;

   // sequencer registers
   logic [CNT_W-1:0]  samples_ff, samples_in;
   logic [IDX_W-1:0]  h_ff, h_in;
   logic              eol_ff, eol_in;
   logic              flushing_ff, flushing_in;
   logic [IDX_W-1:0]  age_ff, age_in;
   logic              last_ff, last_in;
   logic [IDX_W-1:0]  a_ff, a_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [POS_W-1:0]  v_ff, v_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [MED_W-1:0]  two_m_ff, two_m_in;
   logic [OUT_W-1:0]  out_pos_ff, out_pos_in;
   logic [RANK_W-1:0] out_rank_ff, out_rank_in;
   logic              out_done_ff, out_done_in;

   // derived values
   logic [IDX_W-1:0]  h_cfg;
   logic [CNT_W-1:0]  h_cnt;
   logic [CNT_W-1:0]  start_cnt;
   logic [IDX_W-1:0]  lo_calc;
   logic [CNT_W-1:0]  hi_sum;
   logic [CNT_W-1:0]  samples_m1;
   logic [IDX_W-1:0]  hi_calc;
   logic [RANK_W-1:0] center_rank;
   logic              cur_valid;
   logic [IDX_W-1:0]  j_m1;
   logic [POS_W-1:0]  scr_prev;
   logic              insert_shift;
   logic [IDX_W-1:0]  mid;
   logic [MED_W-1:0]  med_round;
   logic              go_flush;
   logic              go_more;

   logic              div_start;
   logic              div_done;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic [NUM_W-1:0]  div_quot;

   // half_window above the built depth acts as the maximum
   assign h_cfg = (int'(half_window_ff) > MAX_HALF_WINDOW) ? MAX_H
                                                          : IDX_W'(half_window_ff);
   assign h_cnt       = CNT_W'(h_ff);
   assign start_cnt   = (samples_ff < h_cnt) ? samples_ff : h_cnt;
   assign lo_calc     = (age_ff >= h_ff) ? (age_ff - h_ff) : '0;
   assign hi_sum      = CNT_W'(age_ff) + CNT_W'(h_ff);
   assign samples_m1  = samples_ff - 1'b1;
   assign hi_calc     = IDX_W'((hi_sum > samples_m1) ? samples_m1 : hi_sum);
   assign center_rank = rank_ff[age_ff];
   assign cur_valid   = (rank_ff[a_ff] != '0);
   assign j_m1        = j_ff - 1'b1;
   assign scr_prev    = scratch_ff[j_m1];
   assign insert_shift = (j_ff != '0) && (scr_prev > v_ff);
   assign mid         = IDX_W'(n_ff >> 1);
   assign med_round   = (two_m_ff + MED_HALF) >> (POSITION_FRACTION_BITS + 1);
   assign go_flush    = !flushing_ff && eol_ff && (start_cnt != '0);
   assign go_more     = flushing_ff && (age_ff != '0);

   // (2*sum + n*2^F) / (n*2^(F+1)) rounds the mean half up
   assign div_num = (NUM_W'(sum_ff) << 1) + (NUM_W'(n_ff) << POSITION_FRACTION_BITS);
   assign div_den = DEN_W'(n_ff) << (POSITION_FRACTION_BITS + 1);

   lwms_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PLAN;
         end
         ST_PLAN: begin
            state_in = (samples_ff >= h_cnt + 1'b1) ? ST_EMIT : ST_NEXT;
         end
         ST_EMIT: begin
            state_in = (center_rank == '0) ? ST_OUTPUT : ST_GATHER;
         end
         ST_GATHER: begin
            if (cur_valid && median_ff) state_in = ST_INSERT;
            else if (a_ff == hi_ff)     state_in = median_ff ? ST_MEDIAN : ST_DIV_START;
         end
         ST_INSERT: begin
            if (!insert_shift) state_in = (a_ff == hi_ff) ? ST_MEDIAN : ST_GATHER;
         end
         ST_MEDIAN:     state_in = ST_MEDIAN_ADD;
         ST_MEDIAN_ADD: state_in = ST_ROUND;
         ST_ROUND:      state_in = ST_OUTPUT;
         ST_DIV_START:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_done) state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (rsp_ready) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = (go_flush || go_more) ? ST_EMIT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUTPUT);
      div_start = (state_ff == ST_DIV_START);
      shift_en  = (state_ff == ST_IDLE) && req_valid;
   end

   // datapath next values
   always_comb begin
      samples_in  = samples_ff;
      h_in        = h_ff;
      eol_in      = eol_ff;
      flushing_in = flushing_ff;
      age_in      = age_ff;
      last_in     = last_ff;
      a_in        = a_ff;
      hi_in       = hi_ff;
      n_in        = n_ff;
      sum_in      = sum_ff;
      v_in        = v_ff;
      j_in        = j_ff;
      two_m_in    = two_m_ff;
      out_pos_in  = out_pos_ff;
      out_rank_in = out_rank_ff;
      out_done_in = out_done_ff;
      scr_we      = 1'b0;
      scr_waddr   = j_ff;
      scr_wdata   = v_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (samples_ff < CNT_W'(WIN_DEPTH)) samples_in = samples_ff + 1'b1;
               h_in        = h_cfg;
               eol_in      = req_end_of_line;
               flushing_in = 1'b0;
            end
         end
         ST_PLAN: begin
            age_in  = h_ff;
            last_in = eol_ff && (h_ff == '0);
         end
         ST_EMIT: begin
            a_in   = lo_calc;
            hi_in  = hi_calc;
            n_in   = '0;
            sum_in = '0;
            if (center_rank == '0) begin
               out_pos_in  = '0;
               out_rank_in = '0;
               out_done_in = last_ff;
            end
         end
         ST_GATHER: begin
            if (cur_valid && median_ff) begin
               v_in = pos_ff[a_ff];
               j_in = IDX_W'(n_ff);
            end else begin
               if (cur_valid) begin
                  sum_in = sum_ff + SUM_W'(pos_ff[a_ff]);
                  n_in   = n_ff + 1'b1;
               end
               a_in = a_ff + 1'b1;
            end
         end
         ST_INSERT: begin
            scr_we = 1'b1;
            if (insert_shift) begin
               scr_wdata = scr_prev;
               j_in      = j_m1;
            end else begin
               n_in = n_ff + 1'b1;
               a_in = a_ff + 1'b1;
            end
         end
         ST_MEDIAN: begin
            two_m_in = MED_W'(scratch_ff[mid]);
         end
         ST_MEDIAN_ADD: begin
            // odd count doubles the middle, even count adds the lower middle
            two_m_in = two_m_ff + (n_ff[0] ? two_m_ff : MED_W'(scratch_ff[mid - 1'b1]));
         end
         ST_ROUND: begin
            out_pos_in  = (med_round > MED_W'(OUT_LIMIT)) ? OUT_LIMIT
                                                          : med_round[OUT_W-1:0];
            out_rank_in = center_rank;
            out_done_in = last_ff;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               out_pos_in  = (div_quot > NUM_W'(OUT_LIMIT)) ? OUT_LIMIT
                                                            : div_quot[OUT_W-1:0];
               out_rank_in = center_rank;
               out_done_in = last_ff;
            end
         end
         ST_NEXT: begin
            if (go_flush) begin
               age_in      = IDX_W'(start_cnt - 1'b1);
               last_in     = (start_cnt == CNT_W'(1));
               flushing_in = 1'b1;
            end else if (go_more) begin
               age_in  = age_ff - 1'b1;
               last_in = (age_ff == IDX_W'(1));
            end else if (eol_ff) begin
               samples_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         half_window_ff <= '0;
         median_ff      <= 1'b0;
         samples_ff     <= '0;
         flushing_ff    <= 1'b0;
         for (int i = 0; i < WIN_DEPTH; i++) rank_ff[i] <= '0;
      end else begin
         state_ff    <= state_in;
         samples_ff  <= samples_in;
         flushing_ff <= flushing_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HALF_WINDOW:   half_window_ff <= csr_data;
               CSR_MEDIAN_SELECT: median_ff      <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (shift_en) begin
            rank_ff[0] <= req_sample_rank;
            for (int i = 1; i < WIN_DEPTH; i++) rank_ff[i] <= rank_ff[i-1];
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      eol_ff      <= eol_in;
      age_ff      <= age_in;
      last_ff     <= last_in;
      a_ff        <= a_in;
      hi_ff       <= hi_in;
      n_ff        <= n_in;
      sum_ff      <= sum_in;
      v_ff        <= v_in;
      j_ff        <= j_in;
      two_m_ff    <= two_m_in;
      out_pos_ff  <= out_pos_in;
      out_rank_ff <= out_rank_in;
      out_done_ff <= out_done_in;
      if (shift_en) begin
         pos_ff[0] <= req_line_position;
         for (int i = 1; i < WIN_DEPTH; i++) pos_ff[i] <= pos_ff[i-1];
      end
      if (scr_we) scratch_ff[scr_waddr] <= scr_wdata;
   end

   assign csr_ready             = 1'b1;
   assign rsp_smoothed_position = out_pos_ff;
   assign rsp_smoothed_rank     = out_rank_ff;
   assign rsp_line_done         = out_done_ff;

endmodule

>>> design/lwms_checker.sv
// ----------------------------------------------------------------------------
// Line window smoother checker
// Port-level checks on the smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_window_mean_median_smoother_assert.svh"

module lwms_checker
   import lwms_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [OUT_W-1:0]      rsp_smoothed_position,
   input logic [RANK_W-1:0]     rsp_smoothed_rank,
   input logic                  rsp_line_done
);

   // an accepted item keeps the block busy
   `LWMS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // no new item while a result waits
   `LWMS_ASSERT_IMP(a_no_accept_pending, clock, reset, rsp_valid, !req_ready)

   // invalid center gives a zero position
   `LWMS_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && (rsp_smoothed_rank == '0),
                    rsp_smoothed_position == '0)

   // stalled result holds
   `LWMS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_smoothed_position) && $stable(rsp_line_done))

endmodule

bind line_window_mean_median_smoother lwms_checker u_lwms_checker (.*);
